// ===== rtl/wrp_pkg.sv =====
`default_nettype none
package wrp_pkg;

    // table sizing
    localparam int MAX_ENTRIES   = 64;
    localparam int FRACTION_BITS = 16;
    localparam int IDX_W         = $clog2(MAX_ENTRIES);
    localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int CMD_W   = 2;
    localparam int AREA_W  = 32;
    localparam int CONC_W  = 16;
    localparam int FRAC_W  = FRACTION_BITS;
    localparam int PROD_W  = AREA_W + CONC_W;
    localparam int TOTAL_W = 56;

    // split of a total for the scaling multiply
    localparam int LO_W    = 32;
    localparam int HI_W    = TOTAL_W - LO_W;
    localparam int SCALE_W = TOTAL_W + FRAC_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_ADD       = 2'd1,
        CMD_PICK_SURF = 2'd2,
        CMD_PICK_VOL  = 2'd3
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/weighted_region_picker_core.sv =====
`default_nettype none
// weighted region picker: inverse-cdf sampling over two cumulative weight tables
// input channel: command plus add and pick operands, qualified by in_valid/in_stall;
//   a beat is taken when in_valid is high and in_stall is low
// output channel: one result beat per input beat, qualified by out_valid/out_stall
// clear and a refused add go straight to the output step; an add passes through
//   the product, the saturating sum, then the output register
// a pick for n stored entries: multiply, scale, first read, then one start per
//   cycle from the start memory, limited by its single read port, over at most
//   the n stored entries; a full table holds 64
// one item is worked on at a time; in_stall stays high until its result has been
//   moved into the output register, which may still hold the previous result
// the output register holds its beat while out_stall is high; a finished result
//   waits in the block until the output register is free
// reset empties the tables (count and totals cleared) and drops out_valid;
//   the start memories need no clearing pass as only stored entries are used
module weighted_region_picker_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [wrp_pkg::CMD_W-1:0]   command,
    input  wire logic [wrp_pkg::AREA_W-1:0]  surface_area,
    input  wire logic [wrp_pkg::AREA_W-1:0]  cubic_volume,
    input  wire logic [wrp_pkg::CONC_W-1:0]  concentration,
    input  wire logic [wrp_pkg::FRAC_W-1:0]  random_fraction,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [wrp_pkg::IDX_W-1:0]   picked_index,
    output logic                             pick_hit,
    output logic      [wrp_pkg::CNT_W-1:0]   stored_count,
    output logic                             add_refused
);

    import wrp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_MUL,
        S_ADD_SUM,
        S_PICK_MUL,
        S_PICK_SCALE,
        S_PICK_LOAD,
        S_PICK_SCAN,
        S_DONE
    } state_t;

    // control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TOTAL_W-1:0]   surf_total_reg, surf_total_next;
    logic [TOTAL_W-1:0]   vol_total_reg, vol_total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_index_reg, out_index_next;
    logic                 out_hit_reg, out_hit_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;
    logic                 out_refused_reg, out_refused_next;

    // item payload and working values
    cmd_t                 cmd_reg, cmd_next;
    logic [AREA_W-1:0]    area_reg, area_next;
    logic [AREA_W-1:0]    vol_reg, vol_next;
    logic [CONC_W-1:0]    conc_reg, conc_next;
    logic [FRAC_W-1:0]    frac_reg, frac_next;
    logic [PROD_W-1:0]    surf_prod_reg, surf_prod_next;
    logic [PROD_W-1:0]    vol_prod_reg, vol_prod_next;
    logic [LO_W+FRAC_W-1:0] p_lo_reg, p_lo_next;
    logic [HI_W+FRAC_W-1:0] p_hi_reg, p_hi_next;
    logic [TOTAL_W-1:0]   value_reg, value_next;
    logic [TOTAL_W-1:0]   prev_reg, prev_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     res_index_reg, res_index_next;
    logic                 res_hit_reg, res_hit_next;
    logic                 res_refused_reg, res_refused_next;

    // memory ports
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    logic [TOTAL_W-1:0]   surf_rdata;
    logic [TOTAL_W-1:0]   vol_rdata;

    // helpers
    logic                 pick_vol;
    logic [TOTAL_W-1:0]   sel_total;
    logic [TOTAL_W-1:0]   sel_rdata;
    logic [TOTAL_W-1:0]   scan_end;
    logic                 scan_last;
    logic [SCALE_W-1:0]   scale_sum;
    logic [TOTAL_W:0]     surf_sum;
    logic [TOTAL_W:0]     vol_sum;
    logic                 out_free;

    wrp_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_surf_starts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (surf_total_reg),
        .raddr (ram_raddr),
        .rdata (surf_rdata)
    );

    wrp_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_vol_starts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (vol_total_reg),
        .raddr (ram_raddr),
        .rdata (vol_rdata)
    );

    // table selection for picks
    assign pick_vol  = (cmd_reg == CMD_PICK_VOL);
    assign sel_total = pick_vol ? vol_total_reg : surf_total_reg;
    assign sel_rdata = pick_vol ? vol_rdata : surf_rdata;

    // interval end: next start, or the total for the last entry
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign scan_end  = scan_last ? sel_total : sel_rdata;

    // recombine the partial products and drop the fraction bits
    assign scale_sum = {p_hi_reg, {LO_W{1'b0}}} + SCALE_W'(p_lo_reg);

    // saturating running totals
    assign surf_sum = {1'b0, surf_total_reg} + (TOTAL_W + 1)'(surf_prod_reg);
    assign vol_sum  = {1'b0, vol_total_reg} + (TOTAL_W + 1)'(vol_prod_reg);

    assign out_free = !out_valid_reg || !out_stall;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        surf_total_next  = surf_total_reg;
        vol_total_next   = vol_total_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_index_next   = out_index_reg;
        out_hit_next     = out_hit_reg;
        out_count_next   = out_count_reg;
        out_refused_next = out_refused_reg;
        cmd_next         = cmd_reg;
        area_next        = area_reg;
        vol_next         = vol_reg;
        conc_next        = conc_reg;
        frac_next        = frac_reg;
        surf_prod_next   = surf_prod_reg;
        vol_prod_next    = vol_prod_reg;
        p_lo_next        = p_lo_reg;
        p_hi_next        = p_hi_reg;
        value_next       = value_reg;
        prev_next        = prev_reg;
        idx_next         = idx_reg;
        res_index_next   = res_index_reg;
        res_hit_next     = res_hit_reg;
        res_refused_next = res_refused_reg;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[IDX_W-1:0];
        ram_raddr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next         = cmd_t'(command);
                    area_next        = surface_area;
                    vol_next         = cubic_volume;
                    conc_next        = concentration;
                    frac_next        = random_fraction;
                    res_index_next   = '0;
                    res_hit_next     = 1'b0;
                    res_refused_next = 1'b0;
                    case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            count_next      = '0;
                            surf_total_next = '0;
                            vol_total_next  = '0;
                            state_next      = S_DONE;
                        end
                        CMD_ADD:
                        begin
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                res_refused_next = 1'b1;
                                state_next       = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ADD_MUL;
                            end
                        end
                        CMD_PICK_SURF, CMD_PICK_VOL:
                        begin
                            state_next = S_PICK_MUL;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // weights, and the entry start stored at the current count
            S_ADD_MUL:
            begin
                surf_prod_next = area_reg * conc_reg;
                vol_prod_next  = vol_reg * conc_reg;
                ram_we         = 1'b1;
                state_next     = S_ADD_SUM;
            end

            S_ADD_SUM:
            begin
                surf_total_next = surf_sum[TOTAL_W] ? TOTAL_MAX : surf_sum[TOTAL_W-1:0];
                vol_total_next  = vol_sum[TOTAL_W] ? TOTAL_MAX : vol_sum[TOTAL_W-1:0];
                count_next      = count_reg + CNT_W'(1);
                state_next      = S_DONE;
            end

            // total times fraction in two partial products
            S_PICK_MUL:
            begin
                p_lo_next  = sel_total[LO_W-1:0] * frac_reg;
                p_hi_next  = sel_total[TOTAL_W-1:LO_W] * frac_reg;
                state_next = S_PICK_SCALE;
            end

            S_PICK_SCALE:
            begin
                value_next = scale_sum[FRAC_W +: TOTAL_W];
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = '0;
                    state_next = S_PICK_LOAD;
                end
            end

            // first start arrives, fetch the second
            S_PICK_LOAD:
            begin
                prev_next  = sel_rdata;
                idx_next   = '0;
                ram_raddr  = IDX_W'(1);
                state_next = S_PICK_SCAN;
            end

            // one interval per cycle, with the following start read ahead
            S_PICK_SCAN:
            begin
                ram_raddr = idx_reg + IDX_W'(2);
                if ((prev_reg < value_reg) && (scan_end > value_reg))
                begin
                    res_index_next = idx_reg;
                    res_hit_next   = 1'b1;
                    state_next     = S_DONE;
                end
                else if (scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next = sel_rdata;
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_index_next   = res_index_reg;
                    out_hit_next     = res_hit_reg;
                    out_count_next   = count_reg;
                    out_refused_next = res_refused_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, table totals and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            surf_total_reg  <= '0;
            vol_total_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_index_reg   <= '0;
            out_hit_reg     <= 1'b0;
            out_count_reg   <= '0;
            out_refused_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            surf_total_reg  <= surf_total_next;
            vol_total_reg   <= vol_total_next;
            out_valid_reg   <= out_valid_next;
            out_index_reg   <= out_index_next;
            out_hit_reg     <= out_hit_next;
            out_count_reg   <= out_count_next;
            out_refused_reg <= out_refused_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        area_reg        <= area_next;
        vol_reg         <= vol_next;
        conc_reg        <= conc_next;
        frac_reg        <= frac_next;
        surf_prod_reg   <= surf_prod_next;
        vol_prod_reg    <= vol_prod_next;
        p_lo_reg        <= p_lo_next;
        p_hi_reg        <= p_hi_next;
        value_reg       <= value_next;
        prev_reg        <= prev_next;
        idx_reg         <= idx_next;
        res_index_reg   <= res_index_next;
        res_hit_reg     <= res_hit_next;
        res_refused_reg <= res_refused_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign picked_index = out_index_reg;
    assign pick_hit     = out_hit_reg;
    assign stored_count = out_count_reg;
    assign add_refused  = out_refused_reg;

endmodule
`default_nettype wire

// ===== rtl/wrp_ram.sv =====
`default_nettype none
module wrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import wrp_pkg::*;

    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 80;
    localparam int REPORT_LIMIT  = 10;

    // one input beat, as offered to the block
    typedef struct packed {
        cmd_t                cmd;
        logic [AREA_W-1:0]   area;
        logic [AREA_W-1:0]   volume;
        logic [CONC_W-1:0]   conc;
        logic [FRAC_W-1:0]   frac;
    } picker_beat_t;

    // one result beat
    typedef struct packed {
        logic [IDX_W-1:0]    index;
        logic                hit;
        logic [CNT_W-1:0]    count;
        logic                refused;
    } pick_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid        = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    command         = '0;
    logic [AREA_W-1:0]   surface_area    = '0;
    logic [AREA_W-1:0]   cubic_volume    = '0;
    logic [CONC_W-1:0]   concentration   = '0;
    logic [FRAC_W-1:0]   random_fraction = '0;
    logic                out_valid;
    logic                out_stall       = 1'b0;
    logic [IDX_W-1:0]    picked_index;
    logic                pick_hit;
    logic [CNT_W-1:0]    stored_count;
    logic                add_refused;

    weighted_region_picker_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .surface_area    (surface_area),
        .cubic_volume    (cubic_volume),
        .concentration   (concentration),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .picked_index    (picked_index),
        .pick_hit        (pick_hit),
        .stored_count    (stored_count),
        .add_refused     (add_refused)
    );

    // clock and reset
    always #4 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // predicted table state
    logic [TOTAL_W-1:0]  surf_start_tab [MAX_ENTRIES];
    logic [TOTAL_W-1:0]  vol_start_tab  [MAX_ENTRIES];
    logic [TOTAL_W-1:0]  surf_sum    = '0;
    logic [TOTAL_W-1:0]  vol_sum     = '0;
    logic [CNT_W-1:0]    held_entries = '0;

    picker_beat_t        pending_beats [$];
    pick_result_t        awaited_results [$];
    picker_beat_t        live_beat;

    int send_gap_pct    = 0;
    int recv_gap_pct    = 0;
    int hold_requests   = 0;
    int holds_started   = 0;
    int hold_left       = 0;
    int beats_in        = 0;
    int results_checked = 0;
    int hits_seen       = 0;
    int refusals_seen   = 0;
    int mismatches      = 0;

    // running total that clips at the top of its range
    function automatic logic [TOTAL_W-1:0] clipped_sum(logic [TOTAL_W-1:0] sum,
                                                        logic [PROD_W-1:0] weight);
        logic [TOTAL_W:0] wide;
        wide = {1'b0, sum} + {{(TOTAL_W - PROD_W + 1){1'b0}}, weight};
        return wide[TOTAL_W] ? TOTAL_MAX : wide[TOTAL_W-1:0];
    endfunction

    // first stored interval strictly holding the scaled total
    function automatic void locate_interval(input logic by_volume,
                                            input logic [FRAC_W-1:0] frac,
                                            output logic hit,
                                            output logic [IDX_W-1:0] idx);
        logic [TOTAL_W-1:0] sum;
        logic [TOTAL_W-1:0] point;
        logic [TOTAL_W-1:0] lo;
        logic [TOTAL_W-1:0] hi;
        logic [SCALE_W-1:0] prod;
        hit  = 1'b0;
        idx  = '0;
        sum  = by_volume ? vol_sum : surf_sum;
        prod = {{FRAC_W{1'b0}}, sum} * {{TOTAL_W{1'b0}}, frac};
        point = prod[SCALE_W-1:FRAC_W];
        for (int i = 0; i < held_entries && !hit; i++)
        begin
            lo = by_volume ? vol_start_tab[i] : surf_start_tab[i];
            if (i + 1 < held_entries)
                hi = by_volume ? vol_start_tab[i+1] : surf_start_tab[i+1];
            else
                hi = sum;
            if (lo < point && hi > point)
            begin
                hit = 1'b1;
                idx = IDX_W'(i);
            end
        end
    endfunction

    // apply one beat to the predicted tables and work out its result
    function automatic pick_result_t step_picker(picker_beat_t b);
        pick_result_t r;
        logic [PROD_W-1:0] surf_weight;
        logic [PROD_W-1:0] vol_weight;
        logic hit;
        logic [IDX_W-1:0] idx;
        r = '0;
        surf_weight = {{CONC_W{1'b0}}, b.area} * {{AREA_W{1'b0}}, b.conc};
        vol_weight  = {{CONC_W{1'b0}}, b.volume} * {{AREA_W{1'b0}}, b.conc};
        case (b.cmd)
            CMD_CLEAR:
            begin
                held_entries = '0;
                surf_sum     = '0;
                vol_sum      = '0;
            end
            CMD_ADD:
            begin
                if (held_entries >= MAX_ENTRIES)
                    r.refused = 1'b1;
                else
                begin
                    surf_start_tab[held_entries[IDX_W-1:0]] = surf_sum;
                    vol_start_tab[held_entries[IDX_W-1:0]]  = vol_sum;
                    surf_sum     = clipped_sum(surf_sum, surf_weight);
                    vol_sum      = clipped_sum(vol_sum, vol_weight);
                    held_entries = held_entries + 1'b1;
                end
            end
            CMD_PICK_SURF:
            begin
                locate_interval(1'b0, b.frac, hit, idx);
                r.hit   = hit;
                r.index = idx;
            end
            default:
            begin
                locate_interval(1'b1, b.frac, hit, idx);
                r.hit   = hit;
                r.index = idx;
            end
        endcase
        r.count = held_entries;
        return r;
    endfunction

    // driver: offers pending beats, holds a stalled beat steady
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                awaited_results.insert(awaited_results.size(), step_picker(live_beat));
                beats_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    live_beat       = pending_beats.pop_front();
                    command         <= live_beat.cmd;
                    surface_area    <= live_beat.area;
                    cubic_volume    <= live_beat.volume;
                    concentration   <= live_beat.conc;
                    random_fraction <= live_beat.frac;
                    in_valid        <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void report_mismatch(string what, pick_result_t exp_r,
                                            pick_result_t got_r);
        if (mismatches < REPORT_LIMIT)
            $display("%0t: %s: expected index %0d hit %0b count %0d refused %0b,",
                     $realtime, what, exp_r.index, exp_r.hit, exp_r.count, exp_r.refused,
                     " got index %0d hit %0b count %0d refused %0b",
                     got_r.index, got_r.hit, got_r.count, got_r.refused);
        mismatches++;
    endfunction

    // monitor and receiver: checks result beats, drives out_stall
    always @(posedge clk or negedge rst_n)
    begin
        pick_result_t got_r;
        pick_result_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_r = '{index: picked_index, hit: pick_hit, count: stored_count,
                          refused: add_refused};
                if (awaited_results.size() == 0)
                    report_mismatch("result beat with nothing awaited", '0, got_r);
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (got_r.index !== exp_r.index || got_r.hit !== exp_r.hit ||
                        got_r.count !== exp_r.count || got_r.refused !== exp_r.refused)
                        report_mismatch("result beat differs", exp_r, got_r);
                    results_checked++;
                    if (exp_r.hit)
                        hits_seen++;
                    if (exp_r.refused)
                        refusals_seen++;
                end
            end
            // long hold-off on request, otherwise random stalls
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (holds_started != hold_requests)
            begin
                holds_started <= holds_started + 1;
                hold_left     <= LONG_HOLD;
                out_stall     <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // random value biased towards the edges of its range
    function automatic logic [31:0] edgy_value(int bits);
        logic [31:0] v;
        case ($urandom_range(4))
            0:       v = $urandom;
            1:       v = $urandom_range(255);
            2:       v = ~$urandom_range(255);
            3:       v = $urandom >> $urandom_range(31);
            default: v = '0;
        endcase
        return v & 32'((64'd1 << bits) - 1);
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(FRAC_W-1){1'b0}}};
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    task automatic queue_beat(cmd_t cmd, logic [AREA_W-1:0] area,
                              logic [AREA_W-1:0] volume, logic [CONC_W-1:0] conc,
                              logic [FRAC_W-1:0] frac);
        picker_beat_t beat;
        beat.cmd    = cmd;
        beat.area   = area;
        beat.volume = volume;
        beat.conc   = conc;
        beat.frac   = frac;
        pending_beats.insert(pending_beats.size(), beat);
    endtask

    // directed beats: empty table, extreme weights, zero weights, boundaries
    task automatic queue_directed();
        queue_beat(CMD_PICK_SURF, '0, '0, '0, '1);
        queue_beat(CMD_PICK_VOL, '1, '1, '1, '1);
        queue_beat(CMD_ADD, '1, '1, '1, '0);
        queue_beat(CMD_ADD, '0, '0, '0, '1);
        queue_beat(CMD_ADD, 32'd1, '1, 16'd1, '0);
        queue_beat(CMD_PICK_SURF, '0, '0, '0, '0);
        queue_beat(CMD_PICK_SURF, '0, '0, '0, '1);
        queue_beat(CMD_PICK_VOL, '0, '0, '0, 16'h8000);
        queue_beat(CMD_PICK_VOL, '0, '0, '0, 16'h0001);
        queue_beat(CMD_CLEAR, '1, '1, '1, '1);
        queue_beat(CMD_PICK_VOL, '0, '0, '0, 16'h8000);
        queue_beat(CMD_ADD, 32'd100, 32'd100, 16'h0100, '0);
        queue_beat(CMD_ADD, 32'd100, 32'd100, 16'h0100, '0);
        // scaled value lands exactly on the second start
        queue_beat(CMD_PICK_SURF, '0, '0, '0, 16'h8000);
        queue_beat(CMD_PICK_VOL, '0, '0, '0, 16'h4000);
        queue_beat(CMD_PICK_VOL, '0, '0, '0, 16'hC000);
        queue_beat(CMD_ADD, '0, 32'd7, 16'h0100, '0);
        queue_beat(CMD_PICK_SURF, '0, '0, '0, '1);
        queue_beat(CMD_PICK_VOL, '0, '0, '0, '1);
        queue_beat(CMD_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 16'hAAAA);
        queue_beat(CMD_PICK_SURF, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 16'h5555);
        queue_beat(CMD_PICK_VOL, '1, '1, '1, 16'hFFFE);
        queue_beat(CMD_CLEAR, '0, '0, '0, '0);
    endtask

    // sessions: clear, a run of adds, then picks with some noise mixed in
    task automatic queue_sessions(int budget);
        int left;
        int adds;
        int picks;
        left = budget;
        while (left > 0)
        begin
            queue_beat(CMD_CLEAR, $urandom, $urandom, 16'($urandom), 16'($urandom));
            if ($urandom_range(7) == 0)
                adds = $urandom_range(MAX_ENTRIES + 6, MAX_ENTRIES - 4);
            else
                adds = $urandom_range(12, 1);
            for (int i = 0; i < adds; i++)
                queue_beat(CMD_ADD, edgy_value(AREA_W), edgy_value(AREA_W),
                           CONC_W'(edgy_value(CONC_W)), 16'($urandom));
            picks = $urandom_range(25, 5);
            for (int i = 0; i < picks; i++)
            begin
                if ($urandom_range(9) == 0)
                    queue_beat(cmd_t'($urandom_range(3)), edgy_value(AREA_W),
                               edgy_value(AREA_W), CONC_W'(edgy_value(CONC_W)),
                               pick_fraction());
                else
                    queue_beat($urandom_range(1) ? CMD_PICK_VOL : CMD_PICK_SURF,
                               $urandom, $urandom, 16'($urandom), pick_fraction());
            end
            left -= 1 + adds + picks;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || awaited_results.size() != 0);
    endtask

    // phase: set idling, queue beats, ask for one long hold-off, then drain
    task automatic run_phase(int send_gap, int recv_gap, int budget, bit directed);
        send_gap_pct = send_gap;
        recv_gap_pct = recv_gap;
        if (directed)
            queue_directed();
        queue_sessions(budget);
        hold_requests++;
        wait_drained();
    endtask

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        run_phase(20, 83, 600, 1'b1);
        run_phase(83, 20, 600, 1'b0);
        run_phase(0, 0, 600, 1'b0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d beats in and %0d results checked, %0d picks hit, %0d adds refused",
                 beats_in, results_checked, hits_seen, refusals_seen);
        $display("three idling phases, each with a %0d-cycle hold-off; %0d mismatches",
                 LONG_HOLD, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
